/* rtl/dac_pkg.sv */
package dac_pkg;

  typedef enum logic [2:0] {
    M_IDLE    = 3'd0,
    M_MOVING  = 3'd1,
    M_GOING   = 3'd2,
    M_HOMING  = 3'd3,
    M_PARKING = 3'd4,
    M_ERROR   = 3'd5
  } mode_t;

  typedef enum logic [3:0] {
    CMD_NONE  = 4'd0,
    CMD_MOVE  = 4'd1,
    CMD_GOTO  = 4'd2,
    CMD_STOP  = 4'd3,
    CMD_HOME  = 4'd4,
    CMD_PARK  = 4'd5,
    CMD_ABORT = 4'd6,
    CMD_OPEN  = 4'd7,
    CMD_CLOSE = 4'd8
  } cmd_t;

  localparam logic [2:0] SH_NONE        = 3'd0;
  localparam logic [2:0] SH_OPEN_BOTH   = 3'd1;
  localparam logic [2:0] SH_OPEN_UPPER  = 3'd2;
  localparam logic [2:0] SH_CLOSE_BOTH  = 3'd3;
  localparam logic [2:0] SH_CLOSE_UPPER = 3'd4;
  localparam logic [2:0] SH_ABORT       = 3'd5;

  localparam logic [2:0] REG_TICKS   = 3'd0;
  localparam logic [2:0] REG_TOL     = 3'd1;
  localparam logic [2:0] REG_TIMEOUT = 3'd2;
  localparam logic [2:0] REG_PARK    = 3'd3;
  localparam logic [2:0] REG_PBS     = 3'd4;
  localparam logic [2:0] REG_SHPRES  = 3'd5;

  typedef enum logic [2:0] {
    C_IDLE,
    C_DIV,
    C_MOD,
    C_UPDATE,
    C_OUT
  } ctl_state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;      // capture item, step ticks
    logic div_start; // start tick / divider
    logic mod_start; // start quotient mod turn
    logic pos_write; // store new position
    logic update;    // run the mode update
  } dac_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic is_pulse;
    logic div_done;
    logic mod_done;
  } dac_stat_t;

  // Shortest-path distance on the ring, in 16-bit arithmetic
  function automatic logic [15:0] ring_dist(input logic [15:0] a, input logic [15:0] b,
                                            input logic [15:0] n);
    logic [15:0] d;
    begin
      d = (b > a) ? (b - a) : (a - b);
      ring_dist = (d > (n >> 1)) ? (n - d) : d;
    end
  endfunction

endpackage

/* rtl/dome_azimuth_controller.sv */
// Pulse item: reciprocal multiply for the encoder divider, then a restoring modulo by the
// turn size, then into the output register; update item: mode update, then into the output
// register. One item at a time; the next is taken the cycle after its result enters the
// output register, and the result waits while that register is full and not being read.
// Reset: synchronous, active high; registers to defaults, mode idle, counts zero.
module dome_azimuth_controller import dac_pkg::*; #(
  parameter int ENCODER_DIVIDER = 1
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // op, pulse_ccw, command[3:0], cmd_ccw, cmd_target[15:0], shutter_upper,
  // home_switch_active, now_ms[31:0]
  input  logic [63:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // dome_state[2:0], motor_on, motor_ccw, position[15:0], home_position[15:0],
  // shutter_cmd[2:0]
  output logic [39:0] m_tdata,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  dac_cmd_t    cmd;
  dac_stat_t   stat;
  logic        busy, result_ready, in_fire;
  logic [39:0] result;

  assign s_tready = !busy;
  assign in_fire  = s_tvalid && s_tready;

  dac_control u_ctl (
    .clk(clk), .rst(rst), .in_fire(in_fire), .out_free(!m_tvalid || m_tready),
    .stat(stat), .cmd(cmd), .busy(busy), .result_ready(result_ready)
  );

  dac_datapath #(.ENCODER_DIVIDER(ENCODER_DIVIDER)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .stat(stat), .in_data(s_tdata[56:0]),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data), .out_data(result)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (rst) m_tvalid <= 1'b0;
    else if (result_ready) m_tvalid <= 1'b1;
    else if (m_tready) m_tvalid <= 1'b0;
    if (result_ready) m_tdata <= result;
  end

  a_one_load: assert property (@(posedge clk) disable iff (rst)
    cmd.load |-> !busy) else $error("load while busy");
  a_fire_busy: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> busy) else $error("no work after accept");
  a_res_valid: assert property (@(posedge clk) disable iff (rst)
    result_ready |=> m_tvalid) else $error("result lost");

endmodule

/* rtl/dac_divider.sv */
module dac_divider import dac_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [31:0] divisor,
  output logic [31:0] remainder,
  output logic        done
);

  logic [5:0]  count;
  logic        busy;
  logic [31:0] quo;
  logic [32:0] rem;
  logic [32:0] trial;

  assign trial = {rem[31:0], quo[31]} - {1'b0, divisor};

  // Restoring division, one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= 6'd32;
        quo   <= dividend;
        rem   <= '0;
      end else if (busy) begin
        if (!trial[32]) begin
          rem <= trial;
          quo <= {quo[30:0], 1'b1};
        end else begin
          rem <= {rem[31:0], quo[31]};
          quo <= {quo[30:0], 1'b0};
        end
        count <= count - 6'd1;
        if (count == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign remainder = rem[31:0];

endmodule

/* rtl/dac_datapath.sv */
module dac_datapath import dac_pkg::*; #(
  parameter int ENCODER_DIVIDER = 1
) (
  input  logic        clk,
  input  logic        rst,
  input  dac_cmd_t    cmd,
  output dac_stat_t   stat,
  input  logic [56:0] in_data,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output logic [39:0] out_data
);

  // Reciprocal of the encoder divider: q = (x * MAGIC) >> (32 + SHIFT), exact for 32-bit x
  localparam int DIV_SHIFT = $clog2(ENCODER_DIVIDER);
  localparam logic [64:0] DIV_MAGIC_W =
    ((65'd1 << (32 + DIV_SHIFT)) / 65'(ENCODER_DIVIDER)) + 65'd1;
  localparam logic [32:0] DIV_MAGIC = DIV_MAGIC_W[32:0];

  // Configuration registers
  logic [15:0] turn_ticks, arrive_tolerance, park_position;
  logic [31:0] stall_timeout_ms;
  logic        park_before_shutter, shutters_present;

  // Captured item
  logic        op, cmd_ccw, upper, home_sw;
  logic [3:0]  command;
  logic [15:0] cmd_target;
  logic [31:0] now_ms;

  // Controller state
  mode_t       mode;
  logic [31:0] tick_count;
  logic [15:0] cur_position, home_mark, goal_position, watch_position;
  logic        drive_ccw, close_after_park;
  logic [31:0] watch_start_ms;
  logic [2:0]  shutter;

  logic [15:0] turn;
  logic        neg;
  logic [31:0] mag;
  logic [31:0] d_rem;
  logic        d_done;
  logic [31:0] mod_r;
  logic [15:0] new_pos;

  logic [47:0] prod_lo;
  logic [48:0] prod_hi;
  logic [64:0] prod_sum, prod_shift;
  logic [31:0] q_div;
  logic        mul_busy, mul_done;

  assign turn = (turn_ticks == 16'd0) ? 16'd1 : turn_ticks;

  always_ff @(posedge clk) begin
    if (rst) begin
      turn_ticks          <= 16'd1000;
      arrive_tolerance    <= 16'd5;
      stall_timeout_ms    <= 32'd5000;
      park_position       <= 16'd0;
      park_before_shutter <= 1'b0;
      shutters_present    <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TICKS:   turn_ticks          <= cfg_data[15:0];
        REG_TOL:     arrive_tolerance    <= cfg_data[15:0];
        REG_TIMEOUT: stall_timeout_ms    <= cfg_data;
        REG_PARK:    park_position       <= cfg_data[15:0];
        REG_PBS:     park_before_shutter <= cfg_data[0];
        REG_SHPRES:  shutters_present    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Magnitude / encoder divider: partial products, then sum and shift
  assign prod_sum   = {17'd0, prod_lo} + {prod_hi, 16'd0};
  assign prod_shift = prod_sum >> (32 + DIV_SHIFT);

  always_ff @(posedge clk) begin
    if (rst) begin
      mul_busy <= 1'b0;
      mul_done <= 1'b0;
    end else begin
      mul_busy <= cmd.div_start;
      mul_done <= mul_busy;
    end
    if (cmd.div_start) begin
      prod_lo <= 48'(mag) * 48'(DIV_MAGIC[15:0]);
      prod_hi <= 49'(mag) * 49'(DIV_MAGIC[32:16]);
    end
    if (mul_busy) q_div <= prod_shift[31:0];
  end

  // Quotient mod turn
  dac_divider u_div (
    .clk(clk), .rst(rst), .start(cmd.mod_start), .dividend(q_div),
    .divisor({16'd0, turn}), .remainder(d_rem), .done(d_done)
  );

  assign stat.is_pulse = ~op;
  assign stat.div_done = mul_done;
  assign stat.mod_done = d_done;

  // Fold sign back in: negative remainder wraps to turn - r
  assign mod_r   = (neg && d_rem != 32'd0) ? ({16'd0, turn} - d_rem) : d_rem;
  assign new_pos = mod_r[15:0];

  // Update-step combinational decisions
  logic [3:0]  ev;
  logic [2:0]  sh_v;
  logic        halt, at_park, timed_out, still;
  logic [15:0] half, sw_target;
  logic        sw_dir;
  logic [15:0] goal_dist;
  logic        cap_set, park_close;

  assign half      = turn >> 1;
  assign at_park   = ring_dist(cur_position, park_position, turn) < arrive_tolerance;
  assign goal_dist = ring_dist(cur_position, goal_position, turn);
  assign timed_out = (now_ms - watch_start_ms) > stall_timeout_ms;
  assign still     = ring_dist(watch_position, cur_position, turn) == 16'd0;
  assign sw_target = (ev == CMD_PARK) ? park_position : home_mark;
  assign sw_dir    = (sw_target > cur_position) ? ((sw_target - cur_position) > half)
                                                : !((cur_position - sw_target) > half);
  assign cap_set   = (command == CMD_CLOSE) && park_before_shutter && !at_park;
  assign park_close = (mode == M_PARKING) && !halt && (goal_dist < arrive_tolerance) &&
                      (close_after_park || cap_set);

  always_comb begin
    ev   = (command <= CMD_CLOSE) ? command : CMD_NONE;
    sh_v = SH_NONE;
    if (ev == CMD_ABORT && shutters_present) sh_v = SH_ABORT;
    if (ev == CMD_OPEN || ev == CMD_CLOSE) begin
      if (!park_before_shutter || at_park) begin
        if (ev == CMD_OPEN) sh_v = upper ? SH_OPEN_UPPER : SH_OPEN_BOTH;
        else sh_v = upper ? SH_CLOSE_UPPER : SH_CLOSE_BOTH;
        ev = CMD_NONE;
      end else begin
        ev = CMD_PARK;
      end
    end
    halt = (ev == CMD_STOP) || (ev == CMD_ABORT);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode             <= M_IDLE;
      tick_count       <= '0;
      cur_position     <= '0;
      home_mark        <= '0;
      goal_position    <= '0;
      drive_ccw        <= 1'b0;
      watch_start_ms   <= '0;
      watch_position   <= '0;
      close_after_park <= 1'b0;
      shutter          <= SH_NONE;
      op               <= 1'b0;
    end else begin
      // Capture item and step the tick count on a pulse
      if (cmd.load) begin
        op         <= in_data[0];
        command    <= in_data[5:2];
        cmd_ccw    <= in_data[6];
        cmd_target <= in_data[22:7];
        upper      <= in_data[23];
        home_sw    <= in_data[24];
        now_ms     <= in_data[56:25];
        shutter    <= SH_NONE;
        if (!in_data[0]) begin
          logic [31:0] t;
          t = in_data[1] ? tick_count + 32'd1 : tick_count - 32'd1;
          tick_count <= t;
          neg <= t[31];
          mag <= t[31] ? (32'd0 - t) : t;
        end
      end
      if (cmd.pos_write) cur_position <= new_pos;
      // Mode update
      if (cmd.update) begin
        shutter <= park_close ? SH_CLOSE_BOTH : sh_v;
        if (cap_set) close_after_park <= 1'b1;
        case (mode)
          M_HOMING: begin
            if (halt) mode <= M_IDLE;
            else if (home_sw) begin
              home_mark    <= '0;
              tick_count   <= '0;
              cur_position <= '0;
              mode         <= M_IDLE;
            end else if (timed_out) begin
              if (still) mode <= M_ERROR;
              else begin
                watch_start_ms <= now_ms;
                watch_position <= cur_position;
              end
            end
          end
          M_MOVING: begin
            if (home_sw) home_mark <= cur_position;
            if (halt) mode <= M_IDLE;
          end
          M_GOING: begin
            if (home_sw) home_mark <= cur_position;
            if (halt || goal_dist < arrive_tolerance) mode <= M_IDLE;
            else if (timed_out) begin
              if (still) mode <= M_ERROR;
              else begin
                watch_start_ms <= now_ms;
                watch_position <= cur_position;
              end
            end
          end
          M_PARKING: begin
            if (halt) mode <= M_IDLE;
            else if (goal_dist < arrive_tolerance) begin
              mode <= M_IDLE;
            end else if (timed_out) begin
              if (still) mode <= M_ERROR;
              else begin
                watch_start_ms <= now_ms;
                watch_position <= cur_position;
              end
            end
          end
          default: begin
            if (ev == CMD_HOME) begin
              watch_start_ms <= now_ms;
              watch_position <= cur_position;
              mode           <= M_HOMING;
              drive_ccw      <= sw_dir;
            end else if (ev == CMD_MOVE) begin
              mode      <= M_MOVING;
              drive_ccw <= cmd_ccw;
            end else if (ev == CMD_PARK) begin
              watch_start_ms <= now_ms;
              watch_position <= cur_position;
              mode           <= M_PARKING;
              goal_position  <= park_position;
              drive_ccw      <= sw_dir;
            end else if (ev == CMD_GOTO) begin
              watch_start_ms <= now_ms;
              watch_position <= cur_position;
              mode           <= M_GOING;
              goal_position  <= cmd_target;
              drive_ccw      <= cmd_ccw;
            end
          end
        endcase
      end
    end
  end

  // Result: dome_state, motor_on, motor_ccw, position, home_position, shutter_cmd
  assign out_data = {shutter, home_mark, cur_position, drive_ccw,
                     (mode == M_MOVING || mode == M_GOING || mode == M_HOMING ||
                      mode == M_PARKING), mode};

endmodule

/* rtl/dac_control.sv */
module dac_control import dac_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_fire,
  input  logic      out_free,
  input  dac_stat_t stat,
  output dac_cmd_t  cmd,
  output logic      busy,
  output logic      result_ready
);

  ctl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= C_IDLE;
    else state <= state_next;
  end

  // Sequence: load, then divide and modulo for a pulse or mode update otherwise, then deliver
  always_comb begin
    state_next   = state;
    cmd          = '0;
    result_ready = 1'b0;
    case (state)
      C_IDLE: begin
        if (in_fire) begin
          cmd.load   = 1'b1;
          state_next = C_UPDATE;
        end
      end
      C_UPDATE: begin
        if (stat.is_pulse) begin
          cmd.div_start = 1'b1;
          state_next    = C_DIV;
        end else begin
          cmd.update = 1'b1;
          state_next = C_OUT;
        end
      end
      C_DIV: begin
        if (stat.div_done) begin
          cmd.mod_start = 1'b1;
          state_next    = C_MOD;
        end
      end
      C_MOD: begin
        if (stat.mod_done) begin
          cmd.pos_write = 1'b1;
          state_next    = C_OUT;
        end
      end
      C_OUT: begin
        if (out_free) begin
          result_ready = 1'b1;
          state_next   = C_IDLE;
        end
      end
      default: state_next = C_IDLE;
    endcase
  end

  assign busy = (state != C_IDLE);

endmodule
